// ===== rtl/core/blpg_pkg.sv =====
`timescale 1ns / 1ps

package blpg_pkg;

    // Coordinate width of the endpoint and pixel fields.
    localparam int COORD_BITS = 12;
    // Walking position: one bit of headroom over a coordinate, signed.
    localparam int POS_W      = COORD_BITS + 1;
    // Error term and its increments: twice a coordinate span, signed.
    localparam int ERR_W      = COORD_BITS + 3;
    localparam int COLOR_W    = 8;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // Decoded line setup, handed from the input stage to the pixel stage.
    typedef struct packed {
        logic                     cmd;
        logic signed [POS_W-1:0]  col;
        logic signed [POS_W-1:0]  row;
        logic signed [POS_W-1:0]  final_pos;
        logic signed [ERR_W-1:0]  err;
        logic signed [ERR_W-1:0]  inc_same;
        logic signed [ERR_W-1:0]  inc_change;
        logic                     steep;
        logic                     up;
        logic [COLOR_W-1:0]       color;
    } t_setup;

endpackage

// ===== rtl/core/blpg_setup.sv =====
`timescale 1ns / 1ps

module blpg_setup import blpg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_command,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  logic [COLOR_W-1:0]    i_line_color,
    output logic                  o_valid,
    output t_setup                o_setup,
    input  logic                  i_take
);

    logic signed [POS_W-1:0] x1, y1, x2, y2, dx, dy, ax_full, ay_full;
    logic [COORD_BITS-1:0]   ax, ay;
    logic signed [ERR_W-1:0] ax_e, ay_e;
    logic                    dx_pos, dy_pos, shallow;
    t_setup                  n_setup;
    t_setup                  r_setup;
    logic                    r_valid;

    assign x1 = signed'({1'b0, i_x_start});
    assign y1 = signed'({1'b0, i_y_start});
    assign x2 = signed'({1'b0, i_x_end});
    assign y2 = signed'({1'b0, i_y_end});
    assign dx = x2 - x1;
    assign dy = y2 - y1;

    assign ax_full = dx[POS_W-1] ? -dx : dx;
    assign ay_full = dy[POS_W-1] ? -dy : dy;
    assign ax      = ax_full[COORD_BITS-1:0];
    assign ay      = ay_full[COORD_BITS-1:0];
    assign ax_e    = signed'(ERR_W'(ax));
    assign ay_e    = signed'(ERR_W'(ay));

    assign dx_pos  = !dx[POS_W-1] && (dx != '0);
    assign dy_pos  = !dy[POS_W-1] && (dy != '0);
    assign shallow = ax > ay;

    always_comb begin
        n_setup       = '0;
        n_setup.cmd   = i_command;
        n_setup.color = i_line_color;
        // Slope sign: positive when dx and dy point the same way.
        n_setup.up    = dx_pos ^ dy[POS_W-1];
        n_setup.steep = !shallow;
        if (shallow) begin
            n_setup.col        = dx_pos ? x1 : x2;
            n_setup.row        = dx_pos ? y1 : y2;
            n_setup.final_pos  = dx_pos ? x2 : x1;
            n_setup.inc_same   = ay_e <<< 1;
            n_setup.err        = (ay_e <<< 1) - ax_e;
            n_setup.inc_change = (ay_e - ax_e) <<< 1;
        end else begin
            n_setup.col        = dy_pos ? x1 : x2;
            n_setup.row        = dy_pos ? y1 : y2;
            n_setup.final_pos  = dy_pos ? y2 : y1;
            n_setup.inc_same   = ax_e <<< 1;
            n_setup.err        = (ax_e <<< 1) - ay_e;
            n_setup.inc_change = (ax_e - ay_e) <<< 1;
        end
    end

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_setup = r_setup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_setup <= n_setup;
        end
    end

endmodule

// ===== rtl/core/blpg_step.sv =====
`timescale 1ns / 1ps

module blpg_step import blpg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_setup                i_setup,
    output logic                  o_take,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [COLOR_W-1:0]    o_pixel_color,
    output logic                  o_last_pixel
);

    logic signed [POS_W-1:0] r_col, r_row, r_final;
    logic signed [ERR_W-1:0] r_err, r_inc_same, r_inc_change;
    logic                    r_steep, r_up, r_active;
    logic [COLOR_W-1:0]      r_color;

    logic signed [POS_W-1:0] c_col, c_row, c_final, c_major, c_minor_inc;
    logic signed [ERR_W-1:0] c_err, c_inc_same, c_inc_change;
    logic                    c_steep, c_up;
    logic [COLOR_W-1:0]      c_color;
    logic signed [POS_W-1:0] n_col, n_row;
    logic signed [ERR_W-1:0] n_err;
    logic                    start, emit, fire, last, step;

    logic                    r_out_valid, r_out_last;
    logic [COORD_BITS-1:0]   r_out_x, r_out_y;
    logic [COLOR_W-1:0]      r_out_color;

    assign start = (i_setup.cmd == CMD_START);
    assign emit  = start || r_active;
    assign fire  = i_valid && (!r_out_valid || i_ready);
    assign o_take = fire;

    // A start command walks from the fresh setup; a next command from the held line.
    assign c_col        = start ? i_setup.col        : r_col;
    assign c_row        = start ? i_setup.row        : r_row;
    assign c_final      = start ? i_setup.final_pos  : r_final;
    assign c_err        = start ? i_setup.err        : r_err;
    assign c_inc_same   = start ? i_setup.inc_same   : r_inc_same;
    assign c_inc_change = start ? i_setup.inc_change : r_inc_change;
    assign c_steep      = start ? i_setup.steep      : r_steep;
    assign c_up         = start ? i_setup.up         : r_up;
    assign c_color      = start ? i_setup.color      : r_color;

    assign c_major = c_steep ? c_row : c_col;
    assign last    = c_major >= c_final;
    // Positive slope steps on error >= 0, negative slope only on error > 0.
    assign step    = !c_err[ERR_W-1] && (c_up || (c_err != '0));
    assign c_minor_inc = !step ? POS_W'(0) : (c_up ? POS_W'(1) : '1);

    assign n_col = c_steep ? c_col + c_minor_inc : c_col + POS_W'(1);
    assign n_row = c_steep ? c_row + POS_W'(1)   : c_row + c_minor_inc;
    assign n_err = c_err + (step ? c_inc_change : c_inc_same);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= emit;
                if (emit) begin
                    r_active <= !last;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (fire && emit) begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_err        <= n_err;
            r_final      <= c_final;
            r_inc_same   <= c_inc_same;
            r_inc_change <= c_inc_change;
            r_steep      <= c_steep;
            r_up         <= c_up;
            r_color      <= c_color;
            r_out_x      <= c_col[COORD_BITS-1:0];
            r_out_y      <= c_row[COORD_BITS-1:0];
            r_out_color  <= c_color;
            r_out_last   <= last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && emit && last |=> !r_active)
        else $error("line still active after its last pixel");

    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && start |=> r_out_valid)
        else $error("start command produced no pixel");

    a_idle_next_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !start && !r_active |=> !r_out_valid)
        else $error("next command without a line produced a pixel");

    a_major_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> ((r_steep ? r_row : r_col) <= r_final))
        else $error("walk passed the final position");

endmodule

// ===== rtl/core/bresenham_line_pixel_generator_top.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-----------------------------------------
// command  | in        | i_valid / o_ready   | i_command, i_x_start, i_y_start,
//          |           |                     | i_x_end, i_y_end, i_line_color
// pixel    | out       | o_valid / i_ready   | o_pixel_x, o_pixel_y, o_pixel_color,
//          |           |                     | o_last_pixel
//
// One command per clock while o_ready is high; pixels pass setup, then output register.
// The rate is set by the pixel stage loop: select, one error add and one compare.
// Reset (i_rst_n low at a clock edge) drops any running line and empties both stages.
// A stalled pixel holds in the output register; the input stage still takes one
// more command, and the command channel stalls only when both are full.

module bresenham_line_pixel_generator_top import blpg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_command,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  logic [COLOR_W-1:0]    i_line_color,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [COLOR_W-1:0]    o_pixel_color,
    output logic                  o_last_pixel
);

    // Hand-off between the setup register and the pixel stage.
    logic   setup_valid;
    logic   setup_take;
    t_setup setup;

    // Input stage: decode endpoints into start point, error term and increments,
    // and register the result for the pixel stage.
    blpg_setup u_setup (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .i_line_color (i_line_color),
        .o_valid      (setup_valid),
        .o_setup      (setup),
        .i_take       (setup_take)
    );

    // Pixel stage: hold the walking line, emit one pixel per transfer and
    // advance the error; a next command with no line is dropped here.
    blpg_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (setup_valid),
        .i_setup       (setup),
        .o_take        (setup_take),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

endmodule
